// ===== rtl/core/mpss_pkg.sv =====
// Shared types, codes and constants of the motor power scale solver.
package mpss_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned SumW      = 61;  // signed width of A, B and C
  localparam int unsigned MagW      = 60;  // magnitude width of A, B and C
  localparam int unsigned NormW     = 30;  // magnitude width after normalization
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 15;

  localparam logic [31:0] FrictionReset  = 32'd117467;
  localparam logic [31:0] TorqueReset    = 32'd366414;
  localparam logic [31:0] ResistReset    = 32'd2194460;
  localparam logic [31:0] StaticReset    = 32'd36909875;
  localparam logic [SumW-1:0] AMinUnits  = SumW'(4295);

  localparam logic [15:0] SCALE_ONE  = 16'd32768;
  localparam logic [15:0] SCALE_ZERO = 16'd0;

  localparam logic [1:0] OUT_ROOT      = 2'd0;
  localparam logic [1:0] OUT_NO_DEMAND = 2'd1;
  localparam logic [1:0] OUT_OVER      = 2'd2;
  localparam logic [1:0] OUT_NO_ROOT   = 2'd3;

  localparam logic [1:0] REG_FRICTION = 2'd0;
  localparam logic [1:0] REG_TORQUE   = 2'd1;
  localparam logic [1:0] REG_RESIST   = 2'd2;
  localparam logic [1:0] REG_STATIC   = 2'd3;

  typedef struct packed {
    logic [31:0] kw;
    logic [31:0] k1;
    logic [31:0] kr;
    logic [31:0] pa;
  } coeff_t;

  typedef struct packed {
    logic                   mode;
    logic signed [SumW-1:0] a;
    logic signed [SumW-1:0] b;
    logic signed [SumW-1:0] c;
  } abc_t;

  typedef struct packed {
    logic [15:0] scale;
    logic [1:0]  outcome;
  } result_t;

  // Result settled early, before the root is known.
  typedef struct packed {
    logic    done;
    result_t res;
  } fix_t;

  typedef struct packed {
    fix_t             fix;
    logic [NormW-1:0] a;
    logic             b_neg;
    logic [NormW-1:0] b;
    logic             c_pos;
    logic [NormW-1:0] c;
  } root_t;

endpackage

// ===== rtl/core/mpss_terms.sv =====
// Per-motor power terms and the sums A, B and C of the quadratic model.
module mpss_terms (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      adv_i,
  input  logic                                      in_valid_i,
  input  logic                                      mode_i,
  input  logic [mpss_pkg::NumMotors-1:0][15:0]      speed_i,
  input  logic [mpss_pkg::NumMotors-1:0][15:0]      current_i,
  input  logic [15:0]                               budget_i,
  input  mpss_pkg::coeff_t                          coeff_i,
  output logic                                      valid_o,
  output mpss_pkg::abc_t                            abc_o
);

  localparam int unsigned N = mpss_pkg::NumMotors;
  localparam int unsigned W = mpss_pkg::SumW;

  // stage 1: squares and cross products
  logic signed [31:0] sq_s [N];
  logic signed [31:0] sq_c [N];
  logic signed [31:0] cs   [N];
  logic        [31:0] cs_neg [N];
  logic [30:0] ss_q [N];
  logic [30:0] cc_q [N];
  logic [30:0] csm_q [N];
  logic        csn_q [N];
  logic        mode1_q, v1_q;
  logic [15:0] bud1_q;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sq_s[i]   = $signed(speed_i[i]) * $signed(speed_i[i]);
      sq_c[i]   = $signed(current_i[i]) * $signed(current_i[i]);
      cs[i]     = $signed(current_i[i]) * $signed(speed_i[i]);
      cs_neg[i] = -cs[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mode1_q <= mode_i;
      bud1_q  <= budget_i;
      for (int i = 0; i < N; i++) begin
        ss_q[i]  <= sq_s[i][30:0];
        cc_q[i]  <= sq_c[i][30:0];
        csn_q[i] <= cs[i][31];
        csm_q[i] <= cs[i][31] ? cs_neg[i][30:0] : cs[i][30:0];
      end
    end
  end

  // stage 2: coefficient products
  logic [62:0] pw [N];
  logic [62:0] pb [N];
  logic [62:0] pi [N];
  logic [54:0] wt_q [N];
  logic [56:0] bt_q [N];
  logic [50:0] it_q [N];
  logic        bn2_q [N];
  logic        mode2_q, v2_q;
  logic [15:0] bud2_q;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      pw[i] = {31'b0, coeff_i.kw} * {32'b0, ss_q[i]};
      pb[i] = {31'b0, coeff_i.k1} * {32'b0, csm_q[i]};
      pi[i] = {31'b0, coeff_i.kr} * {32'b0, cc_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mode2_q <= mode1_q;
      bud2_q  <= bud1_q;
      for (int i = 0; i < N; i++) begin
        wt_q[i]  <= pw[i][62:8];
        bt_q[i]  <= pb[i][62:6];
        it_q[i]  <= pi[i][62:12];
        bn2_q[i] <= csn_q[i];
      end
    end
  end

  // stage 3: pair sums and the static part less the budget
  logic signed [W-1:0] bs [N];
  logic signed [W-1:0] w01_q, w23_q, b01_q, b23_q, i01_q, i23_q, fixed_q;
  logic                mode3_q, v3_q;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      bs[i] = bn2_q[i] ? -W'(bt_q[i]) : W'(bt_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mode3_q <= mode2_q;
      w01_q   <= W'(wt_q[0]) + W'(wt_q[1]);
      w23_q   <= W'(wt_q[2]) + W'(wt_q[3]);
      b01_q   <= bs[0] + bs[1];
      b23_q   <= bs[2] + bs[3];
      i01_q   <= W'(it_q[0]) + W'(it_q[1]);
      i23_q   <= W'(it_q[2]) + W'(it_q[3]);
      fixed_q <= W'({coeff_i.pa, 10'b0}) - W'({bud2_q, 26'b0});
    end
  end

  // stage 4: pick A and C by mode
  logic signed [W-1:0] sum_w, sum_i;
  mpss_pkg::abc_t      abc_q;
  logic                v4_q;

  assign sum_w = w01_q + w23_q;
  assign sum_i = i01_q + i23_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      abc_q.mode <= mode3_q;
      abc_q.a    <= mode3_q ? sum_i : sum_w;
      abc_q.b    <= b01_q + b23_q;
      abc_q.c    <= (mode3_q ? sum_w : sum_i) + fixed_q;
    end
  end

  assign valid_o = v4_q;
  assign abc_o   = abc_q;

endmodule

// ===== rtl/core/mpss_norm.sv =====
// Early outcomes, normalization of A, B and C, and the discriminant.
module mpss_norm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  mpss_pkg::abc_t       abc_i,
  output logic                 valid_o,
  output mpss_pkg::root_t      pay_o,
  output logic [63:0]          disc_o
);

  localparam int unsigned W  = mpss_pkg::SumW;
  localparam int unsigned M  = mpss_pkg::MagW;
  localparam int unsigned NW = mpss_pkg::NormW;

  typedef struct packed {
    logic         over;
    logic         no_demand;
    logic [M-1:0] a;
    logic         b_neg;
    logic [M-1:0] b;
    logic         c_pos;
    logic         c_neg;
    logic [M-1:0] c;
  } mag_t;

  // stage 5: flags and magnitudes
  logic signed [W-1:0] neg_b, neg_c;
  logic                c_nz;
  mag_t mag5_q;
  logic v5_q;

  assign neg_b = -abc_i.b;
  assign neg_c = -abc_i.c;
  assign c_nz  = (abc_i.c != '0);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag5_q.over      <= !abc_i.mode && !abc_i.c[W-1] && c_nz;
      mag5_q.no_demand <= abc_i.a < mpss_pkg::AMinUnits;
      mag5_q.a         <= abc_i.a[M-1:0];
      mag5_q.b_neg     <= abc_i.b[W-1];
      mag5_q.b         <= abc_i.b[W-1] ? neg_b[M-1:0] : abc_i.b[M-1:0];
      mag5_q.c_pos     <= !abc_i.c[W-1] && c_nz;
      mag5_q.c_neg     <= abc_i.c[W-1];
      mag5_q.c         <= abc_i.c[W-1] ? neg_c[M-1:0] : abc_i.c[M-1:0];
    end
  end

  // stage 6: largest magnitude
  logic [M-1:0] m_ab;
  mag_t         mag6_q;
  logic [M-1:0] m6_q;
  logic         v6_q;

  assign m_ab = (mag5_q.b > mag5_q.a) ? mag5_q.b : mag5_q.a;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag6_q <= mag5_q;
      m6_q   <= (mag5_q.c > m_ab) ? mag5_q.c : m_ab;
    end
  end

  // stage 7: shift count that brings every magnitude below 2^30
  logic [5:0] bit_len;
  mag_t       mag7_q;
  logic [4:0] k7_q;
  logic       v7_q;

  always_comb begin
    bit_len = '0;
    for (int i = 0; i < M; i++) begin
      if (m6_q[i]) bit_len = 6'(i + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag7_q <= mag6_q;
      k7_q   <= (bit_len > 6'(NW)) ? 5'(bit_len - 6'(NW)) : 5'd0;
    end
  end

  // stage 8: shift toward zero and settle early outcomes
  logic [M-1:0] sh_a, sh_b, sh_c;
  mpss_pkg::fix_t fix8;
  mpss_pkg::root_t p8_q;
  logic c_neg8_q;
  logic v8_q;

  assign sh_a = mag7_q.a >> k7_q;
  assign sh_b = mag7_q.b >> k7_q;
  assign sh_c = mag7_q.c >> k7_q;

  always_comb begin
    fix8.done        = 1'b0;
    fix8.res.scale   = mpss_pkg::SCALE_ZERO;
    fix8.res.outcome = mpss_pkg::OUT_ROOT;
    if (mag7_q.over) begin
      fix8.done        = 1'b1;
      fix8.res.outcome = mpss_pkg::OUT_OVER;
    end else if (mag7_q.no_demand) begin
      fix8.done        = 1'b1;
      fix8.res.scale   = mpss_pkg::SCALE_ONE;
      fix8.res.outcome = mpss_pkg::OUT_NO_DEMAND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p8_q.fix   <= fix8;
      p8_q.a     <= sh_a[NW-1:0];
      p8_q.b     <= sh_b[NW-1:0];
      p8_q.c     <= sh_c[NW-1:0];
      p8_q.b_neg <= mag7_q.b_neg && (sh_b != '0);
      p8_q.c_pos <= mag7_q.c_pos && (sh_c != '0);
      c_neg8_q   <= mag7_q.c_neg && (sh_c != '0);
    end
  end

  // stage 9: B^2 and A*C
  mpss_pkg::root_t p9_q;
  logic [2*NW-1:0] bb9_q, ac9_q;
  logic c_neg9_q;
  logic v9_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p9_q     <= p8_q;
      c_neg9_q <= c_neg8_q;
      bb9_q    <= (2*NW)'(p8_q.b) * (2*NW)'(p8_q.b);
      ac9_q    <= (2*NW)'(p8_q.a) * (2*NW)'(p8_q.c);
    end
  end

  // stage 10: discriminant B^2 - 4AC
  logic [63:0] bb_x, ac4_x, disc;
  logic        disc_neg;
  mpss_pkg::root_t p10_q;
  logic [63:0] d10_q;
  logic v10_q;

  assign bb_x  = 64'(bb9_q);
  assign ac4_x = 64'({ac9_q, 2'b0});

  always_comb begin
    disc_neg = 1'b0;
    disc     = bb_x;
    if (p9_q.c_pos) begin
      disc_neg = ac4_x > bb_x;
      disc     = bb_x - ac4_x;
    end else if (c_neg9_q) begin
      disc     = bb_x + ac4_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p10_q <= p9_q;
      d10_q <= disc_neg ? 64'd0 : disc;
      if (!p9_q.fix.done && disc_neg) begin
        p10_q.fix.done        <= 1'b1;
        p10_q.fix.res.scale   <= mpss_pkg::SCALE_ZERO;
        p10_q.fix.res.outcome <= mpss_pkg::OUT_NO_ROOT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else if (adv_i) begin
      v5_q  <= valid_i;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  assign valid_o = v10_q;
  assign pay_o   = p10_q;
  assign disc_o  = d10_q;

endmodule

// ===== rtl/core/mpss_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module mpss_sqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  mpss_pkg::root_t  pay_i,
  input  logic [63:0]      disc_i,
  output logic             valid_o,
  output mpss_pkg::root_t  pay_o,
  output logic [31:0]      root_o
);

  localparam int unsigned N = mpss_pkg::SqrtSteps;

  logic [63:0]     rem_q  [N];
  logic [63:0]     root_q [N];
  logic            vld_q  [N];
  mpss_pkg::root_t pay_q  [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2*j);
    logic [63:0]     rem_in, root_in, trial, rem_n, root_n;
    logic            v_in;
    mpss_pkg::root_t p_in;

    if (j == 0) begin : g_first
      assign rem_in  = disc_i;
      assign root_in = '0;
      assign v_in    = valid_i;
      assign p_in    = pay_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign v_in    = vld_q[j-1];
      assign p_in    = pay_q[j-1];
    end

    always_comb begin
      trial = root_in + Bit;
      if (rem_in >= trial) begin
        rem_n  = rem_in - trial;
        root_n = (root_in >> 1) + Bit;
      end else begin
        rem_n  = rem_in;
        root_n = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (adv_i) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[j]  <= rem_n;
        root_q[j] <= root_n;
        pay_q[j]  <= p_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign pay_o   = pay_q[N-1];
  assign root_o  = root_q[N-1][31:0];

endmodule

// ===== rtl/core/mpss_div.sv =====
// Root selection and the pipelined Q1.15 quotient.
module mpss_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  mpss_pkg::root_t   pay_i,
  input  logic [31:0]       root_i,
  output logic              valid_o,
  output mpss_pkg::result_t res_o
);

  localparam int unsigned N = mpss_pkg::DivSteps;

  // stage P1: numerator and denominator of the stable root form
  logic [32:0]    num, den;
  mpss_pkg::fix_t fix1;
  logic [32:0]    num1_q, den1_q;
  mpss_pkg::fix_t fix1_q;
  logic           v1_q;

  always_comb begin
    fix1 = pay_i.fix;
    num  = 33'(root_i) + 33'(pay_i.b);
    den  = 33'({pay_i.a, 1'b0});
    if (!pay_i.fix.done) begin
      fix1.res.outcome = mpss_pkg::OUT_ROOT;
      fix1.res.scale   = mpss_pkg::SCALE_ZERO;
      if (pay_i.b_neg) begin
        if (den == '0) begin
          fix1.done      = 1'b1;
          fix1.res.scale = mpss_pkg::SCALE_ONE;
        end
      end else if (pay_i.c_pos) begin
        fix1.done = 1'b1;
      end else begin
        num = 33'({pay_i.c, 1'b0});
        den = 33'(root_i) + 33'(pay_i.b);
        if (den == '0) fix1.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num1_q <= num;
      den1_q <= den;
      fix1_q <= fix1;
    end
  end

  // stage P2: a root at or above one saturates
  logic [32:0]    rem2_q, den2_q;
  mpss_pkg::fix_t fix2_q;
  logic           v2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem2_q <= num1_q;
      den2_q <= den1_q;
      fix2_q <= fix1_q;
      if (!fix1_q.done && num1_q >= den1_q) begin
        fix2_q.done      <= 1'b1;
        fix2_q.res.scale <= mpss_pkg::SCALE_ONE;
      end
    end
  end

  // restoring division, one quotient bit per stage
  logic [32:0]    rem_q [N];
  logic [32:0]    den_q [N];
  logic [N-1:0]   quo_q [N];
  mpss_pkg::fix_t fix_q [N];
  logic           vld_q [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [32:0]    rem_in, den_in;
    logic [N-1:0]   quo_in;
    mpss_pkg::fix_t fix_in;
    logic           v_in;
    logic [33:0]    dbl, diff;

    if (j == 0) begin : g_first
      assign rem_in = rem2_q;
      assign den_in = den2_q;
      assign quo_in = '0;
      assign fix_in = fix2_q;
      assign v_in   = v2_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
      assign fix_in = fix_q[j-1];
      assign v_in   = vld_q[j-1];
    end

    assign dbl  = {rem_in, 1'b0};
    assign diff = dbl - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (adv_i) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        den_q[j] <= den_in;
        fix_q[j] <= fix_in;
        if (dbl >= {1'b0, den_in}) begin
          rem_q[j] <= diff[32:0];
          quo_q[j] <= {quo_in[N-2:0], 1'b1};
        end else begin
          rem_q[j] <= dbl[32:0];
          quo_q[j] <= {quo_in[N-2:0], 1'b0};
        end
      end
    end
  end

  // final: choose settled result or quotient
  mpss_pkg::result_t res_q;
  logic              vf_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (fix_q[N-1].done) begin
        res_q <= fix_q[N-1].res;
      end else begin
        res_q.scale   <= 16'(quo_q[N-1]);
        res_q.outcome <= mpss_pkg::OUT_ROOT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      vf_q <= vld_q[N-1];
    end
  end

  assign valid_o = vf_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/core/motor_power_scale_solver.sv =====
// Top level of the motor power scale solver: registers, pipeline and output buffer.
//
// Takes one set of four motor speeds and currents per cycle, while the pipeline
// advances, and returns the factor in Q1.15 that brings the modeled total power down
// to the budget, with an outcome code. Every step is pipelined: 4 stages form the
// power terms and sums, 6 normalize and form the discriminant, 32 take the square
// root one bit each, 18 select the root and divide one quotient bit each. The 60th
// stage writes the two-beat output buffer, and a new beat is taken every cycle while
// the pipeline advances. The pipeline halts only while the output buffer holds two
// beats. Coefficient registers take writes at any time and must only be changed while
// the pipeline is empty.
module motor_power_scale_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] speed_0_i,
  input  logic [15:0] speed_1_i,
  input  logic [15:0] speed_2_i,
  input  logic [15:0] speed_3_i,
  input  logic [15:0] current_0_i,
  input  logic [15:0] current_1_i,
  input  logic [15:0] current_2_i,
  input  logic [15:0] current_3_i,
  input  logic [15:0] power_budget_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] scale_o,
  output logic [1:0]  outcome_o
);

  mpss_pkg::coeff_t coeff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q.kw <= mpss_pkg::FrictionReset;
      coeff_q.k1 <= mpss_pkg::TorqueReset;
      coeff_q.kr <= mpss_pkg::ResistReset;
      coeff_q.pa <= mpss_pkg::StaticReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mpss_pkg::REG_FRICTION: coeff_q.kw <= cfg_data_i;
        mpss_pkg::REG_TORQUE:   coeff_q.k1 <= cfg_data_i;
        mpss_pkg::REG_RESIST:   coeff_q.kr <= cfg_data_i;
        mpss_pkg::REG_STATIC:   coeff_q.pa <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances while the output buffer has room
  logic [1:0] cnt_q, cnt_d;
  logic       adv;

  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  logic [mpss_pkg::NumMotors-1:0][15:0] speed, current;
  assign speed   = {speed_3_i, speed_2_i, speed_1_i, speed_0_i};
  assign current = {current_3_i, current_2_i, current_1_i, current_0_i};

  logic            t_valid, n_valid, s_valid, d_valid;
  mpss_pkg::abc_t  abc;
  mpss_pkg::root_t n_pay, s_pay;
  logic [63:0]     disc;
  logic [31:0]     root;
  mpss_pkg::result_t d_res;

  mpss_terms u_terms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .speed_i    (speed),
    .current_i  (current),
    .budget_i   (power_budget_i),
    .coeff_i    (coeff_q),
    .valid_o    (t_valid),
    .abc_o      (abc)
  );

  mpss_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (t_valid),
    .abc_i   (abc),
    .valid_o (n_valid),
    .pay_o   (n_pay),
    .disc_o  (disc)
  );

  mpss_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (n_valid),
    .pay_i   (n_pay),
    .disc_i  (disc),
    .valid_o (s_valid),
    .pay_o   (s_pay),
    .root_o  (root)
  );

  mpss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_valid),
    .pay_i   (s_pay),
    .root_i  (root),
    .valid_o (d_valid),
    .res_o   (d_res)
  );

  // two-beat output buffer
  mpss_pkg::result_t buf_q [2];
  logic wp_q, rp_q;
  logic push, pop;

  assign push  = d_valid && adv;
  assign pop   = out_valid_o && out_ready_i;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= d_res;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign scale_o     = buf_q[rp_q].scale;
  assign outcome_o   = buf_q[rp_q].outcome;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_demand_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == mpss_pkg::OUT_NO_DEMAND |-> scale_o == mpss_pkg::SCALE_ONE)
    else $error("no-demand beat without full scale");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == mpss_pkg::OUT_OVER || outcome_o == mpss_pkg::OUT_NO_ROOT)
    |-> scale_o == mpss_pkg::SCALE_ZERO)
    else $error("over-budget or rootless beat with nonzero scale");

  a_scale_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scale_o <= mpss_pkg::SCALE_ONE)
    else $error("scale above one");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !out_ready_i |=> cnt_q == 2'd2)
    else $error("full buffer lost a beat");

endmodule

// ===== dv/motor_power_scale_solver_tb.sv =====
// Self-checking testbench of the motor power scale solver.
`timescale 1ns / 100ps

module motor_power_scale_solver_tb;

  typedef struct packed {
    logic             mode;
    logic [3:0][15:0] spd;
    logic [3:0][15:0] cur;
    logic [15:0]      budget;
  } motor_set_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = mpss_pkg::REG_FRICTION;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  motor_set_t  drv_set = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] scale_o;
  logic [1:0]  outcome_o;

  motor_set_t         set_q[$];
  mpss_pkg::result_t  expected_q[$];
  mpss_pkg::coeff_t   coeff;
  int          errors = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;
  bit          hold_sets = 1'b0;
  bit          in_taken = 1'b0;
  int          outcome_seen[4] = '{0, 0, 0, 0};
  int          sets_sent = 0;
  motor_set_t  next_set;

  motor_power_scale_solver DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .mode_i(drv_set.mode),
    .speed_0_i(drv_set.spd[0]), .speed_1_i(drv_set.spd[1]),
    .speed_2_i(drv_set.spd[2]), .speed_3_i(drv_set.spd[3]),
    .current_0_i(drv_set.cur[0]), .current_1_i(drv_set.cur[1]),
    .current_2_i(drv_set.cur[2]), .current_3_i(drv_set.cur[3]),
    .power_budget_i(drv_set.budget),
    .out_valid_o, .out_ready_i, .scale_o, .outcome_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint trunc_shift(longint v, int k);
    longint unsigned m;
    m = mag(v) >> k;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned d);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > d) bitv >>= 2;
    while (bitv != 0) begin
      if (d >= r + bitv) begin
        d -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] q15_of(longint unsigned num, longint unsigned den);
    if (num >= den) return mpss_pkg::SCALE_ONE;
    return 16'((num << 15) / den);
  endfunction

  // Solve the budget quadratic for one motor set under the current coefficients.
  function automatic mpss_pkg::result_t solve_scale(motor_set_t s, mpss_pkg::coeff_t k);
    longint w_sum, b_sum, i_sum, a, b, c, sp, cu, cs, d, fixed_p;
    longint unsigned m, bt, root, num, den;
    int sh;
    mpss_pkg::result_t r;
    w_sum = 0; b_sum = 0; i_sum = 0; sh = 0;
    for (int i = 0; i < 4; i++) begin
      sp = longint'($signed(s.spd[i]));
      cu = longint'($signed(s.cur[i]));
      cs = cu * sp;
      bt = (longint'(k.k1) * mag(cs)) >> 6;
      w_sum += longint'((longint'(k.kw) * longint'(sp * sp)) >> 8);
      b_sum += cs < 0 ? -longint'(bt) : longint'(bt);
      i_sum += longint'((longint'(k.kr) * longint'(cu * cu)) >> 12);
    end
    fixed_p = 4 * (longint'(k.pa) << 8) - (longint'(s.budget) << 26);
    if (s.mode) begin
      a = i_sum; c = w_sum + fixed_p;
    end else begin
      a = w_sum; c = i_sum + fixed_p;
    end
    b = b_sum;
    if (!s.mode && c > 0) begin
      r.scale = mpss_pkg::SCALE_ZERO; r.outcome = mpss_pkg::OUT_OVER;
    end else if (a < 4295) begin
      r.scale = mpss_pkg::SCALE_ONE; r.outcome = mpss_pkg::OUT_NO_DEMAND;
    end else begin
      m = mag(a);
      if (mag(b) > m) m = mag(b);
      if (mag(c) > m) m = mag(c);
      while ((m >> sh) >= 64'h4000_0000) sh++;
      a = trunc_shift(a, sh);
      b = trunc_shift(b, sh);
      c = trunc_shift(c, sh);
      d = b * b - 4 * a * c;
      if (d < 0) begin
        r.scale = mpss_pkg::SCALE_ZERO; r.outcome = mpss_pkg::OUT_NO_ROOT;
      end else begin
        root = int_sqrt(d);
        r.outcome = mpss_pkg::OUT_ROOT;
        if (b < 0) begin
          den = 2 * a;
          r.scale = den == 0 ? mpss_pkg::SCALE_ONE : q15_of(root + mag(b), den);
        end else if (c > 0) begin
          r.scale = mpss_pkg::SCALE_ZERO;
        end else begin
          num = 2 * mag(c);
          den = b + root;
          r.scale = den == 0 ? mpss_pkg::SCALE_ZERO : q15_of(num, den);
        end
      end
    end
    return r;
  endfunction

  // Magnitudes spread over all bit positions, signs random.
  function automatic logic [15:0] rand_field();
    logic [15:0] v;
    v = 16'($urandom);
    return 16'($signed(v) >>> $urandom_range(0, 15));
  endfunction

  function automatic motor_set_t rand_set(bit wild);
    motor_set_t s;
    s.mode = 1'($urandom);
    for (int i = 0; i < 4; i++) begin
      s.spd[i] = wild ? 16'($urandom) : rand_field();
      s.cur[i] = wild ? 16'($urandom) : rand_field();
    end
    s.budget = wild ? 16'($urandom) : 16'($urandom) >> $urandom_range(0, 15);
    return s;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mpss_pkg::REG_FRICTION: coeff.kw = val;
      mpss_pkg::REG_TORQUE:   coeff.k1 = val;
      mpss_pkg::REG_RESIST:   coeff.kr = val;
      default:                coeff.pa = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (set_q.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  // Accept beats on both channels; check results against the oldest expectation.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_q.push_back(solve_scale(drv_set, coeff));
      in_taken = 1'b1;
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat", $realtime);
      end else begin
        if (scale_o !== expected_q[0].scale) report("scale", scale_o, expected_q[0].scale);
        if (outcome_o !== expected_q[0].outcome)
          report("outcome", 16'(outcome_o), 16'(expected_q[0].outcome));
        outcome_seen[expected_q[0].outcome]++;
        void'(expected_q.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (!hold_sets && set_q.size() != 0) begin
        next_set = set_q.pop_front();
        drv_set <= next_set;
        in_valid_i <= 1'b1;
        sets_sent++;
        gap_left = gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left = gap_len();
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    motor_set_t s;
    coeff = '{kw: mpss_pkg::FrictionReset, k1: mpss_pkg::TorqueReset,
              kr: mpss_pkg::ResistReset, pa: mpss_pkg::StaticReset};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero, extremes, both modes, tiny and huge budgets.
    for (int md = 0; md < 2; md++) begin
      s = '0; s.mode = md[0];
      set_q.push_back(s);
      s.budget = 16'hFFFF;
      set_q.push_back(s);
      for (int i = 0; i < 4; i++) begin
        s.spd[i] = 16'h7FFF; s.cur[i] = 16'h8000;
      end
      set_q.push_back(s);
      s.budget = 16'h0000;
      set_q.push_back(s);
      for (int i = 0; i < 4; i++) begin
        s.spd[i] = 16'h8000; s.cur[i] = 16'h8000;
      end
      set_q.push_back(s);
      s.budget = 16'hFFFF;
      set_q.push_back(s);
      // Moderate drive: root inside the range, above one, or no real root.
      for (int i = 0; i < 4; i++) begin
        s.spd[i] = 16'd6000; s.cur[i] = 16'd5000;
      end
      s.budget = 16'd12000;
      set_q.push_back(s);
      s.budget = 16'd200;
      set_q.push_back(s);
      for (int i = 0; i < 4; i++) s.cur[i] = -16'sd5000;
      set_q.push_back(s);
      s.budget = 16'd40000;
      set_q.push_back(s);
      s.spd = '0;
      set_q.push_back(s);
    end

    for (int ph = 0; ph < 5; ph++) begin
      calm = (ph == 2);
      for (int n = 0; n < 105; n++) set_q.push_back(rand_set($urandom_range(0, 4) == 0));
      hold_sets = 1'b0;
      // Hold the sender until the pipeline is empty, then change coefficients.
      drain();
      hold_sets = 1'b1;
      case (ph)
        0: for (int r = 0; r < 4; r++) write_reg(2'(r), 32'hFFFF_FFFF);
        1: for (int r = 0; r < 4; r++) write_reg(2'(r), 32'h0);
        2: for (int r = 0; r < 4; r++) write_reg(2'(r), $urandom >> $urandom_range(0, 24));
        3: begin
          write_reg(mpss_pkg::REG_FRICTION, mpss_pkg::FrictionReset);
          write_reg(mpss_pkg::REG_TORQUE, mpss_pkg::TorqueReset << 4);
          write_reg(mpss_pkg::REG_RESIST, mpss_pkg::ResistReset);
          write_reg(mpss_pkg::REG_STATIC, mpss_pkg::StaticReset >> 3);
        end
        default: ;
      endcase
    end

    drain();
    $display("Sent %0d motor sets over five coefficient settings incl. all-zero and all-ones.",
             sets_sent);
    $display("Outcomes: root %0d, no demand %0d, over budget %0d, no real root %0d.",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
